@@ src/fbtdm_pkg.sv @@
// ----------------------------------------------------------------------------
// fbtdm_pkg
// Shared types, codes and helpers for the framebuffer tile dirty map.
// ----------------------------------------------------------------------------
package fbtdm_pkg;

   localparam int TILE_SIZE_DEFAULT  = 16;
   localparam int MAX_WIDTH_DEFAULT  = 128;
   localparam int MAX_HEIGHT_DEFAULT = 128;

   localparam int MAP_SIDE    = 8;
   localparam int PIXEL_W     = 32;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [7:0] RST_FRAME_WIDTH  = 8'd128;
   localparam logic [7:0] RST_FRAME_HEIGHT = 8'd128;
   localparam logic [2:0] RST_PIXEL_BYTES  = 3'd4;
   localparam logic       RST_ALWAYS_FORCE = 1'b0;

   typedef enum logic [1:0] {
      OP_COMPARE = 2'd0,
      OP_CLEAN   = 2'd1,
      OP_QUERY   = 2'd2,
      OP_RESET   = 2'd3
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_PIXEL_BYTES  = 2'd2,
      CSR_ALWAYS_FORCE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic load_item;
      logic rd_en;
      logic commit;
      logic clear_init;
      logic clear_step;
   } dp_cmd_type;

   typedef struct packed {
      logic in_reset;
      logic clear_last;
      logic rsp_free;
   } dp_sts_type;

   // frame size register limited to the largest frame
   function automatic logic [7:0] sat8(logic [7:0] value, int limit);
      logic [7:0] res;
      res = (int'(value) > limit) ? 8'(limit) : value;
      return res;
   endfunction

   // one bit per tile column (or row) whose first pixel lies inside the limit
   function automatic logic [MAP_SIDE-1:0] tiles_in_use(logic [7:0] limit, int tile_size);
      logic [MAP_SIDE-1:0] res;
      for (int i = 0; i < MAP_SIDE; i++) begin
         res[i] = (i * tile_size) < int'(limit);
      end
      return res;
   endfunction

   function automatic logic [3:0] count8(logic [MAP_SIDE-1:0] bits);
      logic [3:0] res;
      res = '0;
      for (int i = 0; i < MAP_SIDE; i++) begin
         res = res + 4'(bits[i]);
      end
      return res;
   endfunction

endpackage

@@ src/framebuffer_tile_dirty_map.sv @@
// ----------------------------------------------------------------------------
// framebuffer_tile_dirty_map
// Tile dirty map with a shadow copy of the frame.
//
//   channel  direction  transfer when           payload
//   req_     in         req_tvalid & tready     tuser command, tdata pixel item
//   rsp_     out        rsp_tvalid & tready     tdata tile result
//   csr_     in         csr_valid & csr_ready   csr_addr index, csr_wdata value
//
// Compare, clean and query: each item goes through transfer, shadow read and
// evaluate; the next item is taken the cycle after the result is loaded.
// Reset command and power-on reset: a clearing pass over all MAX_WIDTH*MAX_HEIGHT
// shadow RAM words through the write port, no item taken meanwhile.
// The evaluate step waits while the result register is full and not taken.
// csr_ready is always high.
// ----------------------------------------------------------------------------
module framebuffer_tile_dirty_map #(
   parameter int TILE_SIZE  = fbtdm_pkg::TILE_SIZE_DEFAULT,
   parameter int MAX_WIDTH  = fbtdm_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = fbtdm_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [1:0] command
   input  logic [1:0]                         req_tuser,
   // [2:0] tile_x, [5:3] tile_y, [9:6] offset_x, [13:10] offset_y,
   // [45:14] pixel, [46] force_req, [47] zero
   input  logic [fbtdm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] tile_dirty, [1] pixel_changed, [8:2] dirty_count, [9] out_of_range,
   // [15:10] zero
   output logic [fbtdm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fbtdm_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [fbtdm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   fbtdm_pkg::dp_cmd_type cmd;
   fbtdm_pkg::dp_sts_type sts;

   logic                          ram_we, ram_re;
   logic [AW-1:0]                 ram_waddr, ram_raddr;
   logic [fbtdm_pkg::PIXEL_W-1:0] ram_wdata, ram_rdata;

   assign csr_ready = 1'b1;

   fbtdm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   fbtdm_dp #(
      .TILE_SIZE  (TILE_SIZE),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   fbtdm_ram #(
      .WIDTH (fbtdm_pkg::PIXEL_W),
      .DEPTH (DEPTH)
   ) u_shadow (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

@@ src/fbtdm_ram.sv @@
// ----------------------------------------------------------------------------
// fbtdm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fbtdm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/fbtdm_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbtdm_ctrl
// Sequencer: accept, shadow read, evaluate, and the shadow clearing pass.
// ----------------------------------------------------------------------------
module fbtdm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  fbtdm_pkg::dp_sts_type  sts,
   output fbtdm_pkg::dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_EVAL  = 4'b0100,
      ST_CLEAR = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      reply_ff, reply_in;

   always_comb begin
      state_in   = state_ff;
      reply_in   = reply_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               if (sts.in_reset) begin
                  cmd.clear_init = 1'b1;
                  reply_in       = 1'b1;
                  state_in       = ST_CLEAR;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_EVAL;
         end
         ST_EVAL: begin
            if (sts.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               reply_in = 1'b0;
               state_in = reply_ff ? ST_EVAL : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         reply_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         reply_ff <= reply_in;
      end
   end

endmodule

@@ src/fbtdm_dp.sv @@
// ----------------------------------------------------------------------------
// fbtdm_dp
// Datapath: registers, item hold, range checks, shadow compare, dirty map
// and result register.
// ----------------------------------------------------------------------------
module fbtdm_dp #(
   parameter int TILE_SIZE  = fbtdm_pkg::TILE_SIZE_DEFAULT,
   parameter int MAX_WIDTH  = fbtdm_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = fbtdm_pkg::MAX_HEIGHT_DEFAULT,
   localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT,
   localparam int AW        = $clog2(DEPTH)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fbtdm_pkg::dp_cmd_type                cmd,
   output fbtdm_pkg::dp_sts_type                sts,
   input  logic [1:0]                           req_tuser,
   input  logic [fbtdm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                 csr_valid,
   input  logic [fbtdm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [fbtdm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [fbtdm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                 ram_we,
   output logic [AW-1:0]                        ram_waddr,
   output logic [fbtdm_pkg::PIXEL_W-1:0]        ram_wdata,
   output logic                                 ram_re,
   output logic [AW-1:0]                        ram_raddr,
   input  logic [fbtdm_pkg::PIXEL_W-1:0]        ram_rdata
);

   localparam int MS     = fbtdm_pkg::MAP_SIDE;
   localparam int PW     = fbtdm_pkg::PIXEL_W;
   localparam int POS_W  = $clog2(MS * TILE_SIZE + 272);
   localparam int IW_MIN = POS_W + $clog2(MAX_WIDTH) + 1;
   localparam int IW     = (IW_MIN > AW) ? IW_MIN : AW;
   localparam int SAT_W  = (MAX_WIDTH < 256) ? MAX_WIDTH : 255;
   localparam int SAT_H  = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 255;
   localparam logic [MS-1:0] RST_COLS = fbtdm_pkg::tiles_in_use(
      fbtdm_pkg::sat8(fbtdm_pkg::RST_FRAME_WIDTH, SAT_W), TILE_SIZE);
   localparam logic [MS-1:0] RST_ROWS = fbtdm_pkg::tiles_in_use(
      fbtdm_pkg::sat8(fbtdm_pkg::RST_FRAME_HEIGHT, SAT_H), TILE_SIZE);

   // configuration
   logic [7:0] frame_width_ff, frame_height_ff;
   logic [2:0] pixel_bytes_ff;
   logic       always_force_ff;

   // held item
   fbtdm_pkg::op_type op_ff;
   logic [2:0]        tx_ff, ty_ff;
   logic [3:0]        ox_ff, oy_ff;
   logic [PW-1:0]     pix_ff;
   logic              force_ff;

   // dirty map, clearing pass, result
   logic [MS*MS-1:0]                   dirty_ff, dirty_in;
   logic [6:0]                         count_ff, count_in;
   logic [AW-1:0]                      clr_addr_ff, clr_addr_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [fbtdm_pkg::RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [7:0]      eff_w, eff_h;
   logic [MS-1:0]   cols, rows;
   logic [MS*MS-1:0] use_mask;
   logic [6:0]      use_count;
   logic [5:0]      tile_idx;
   logic            tile_ok, dirty_cur, oor, force_eff, diff, changed, mark;
   logic [POS_W-1:0] px, py;
   logic [IW-1:0]   idx_full;
   logic [PW-1:0]   bmask;

   function automatic logic [PW-1:0] byte_mask(logic [2:0] nbytes);
      logic [PW-1:0] m;
      case (nbytes)
         3'd0:    m = 32'h0000_0000;
         3'd1:    m = 32'h0000_00FF;
         3'd2:    m = 32'h0000_FFFF;
         3'd3:    m = 32'h00FF_FFFF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   assign eff_w = fbtdm_pkg::sat8(frame_width_ff, SAT_W);
   assign eff_h = fbtdm_pkg::sat8(frame_height_ff, SAT_H);
   assign cols  = fbtdm_pkg::tiles_in_use(eff_w, TILE_SIZE);
   assign rows  = fbtdm_pkg::tiles_in_use(eff_h, TILE_SIZE);
   assign use_count = 7'(fbtdm_pkg::count8(cols)) * 7'(fbtdm_pkg::count8(rows));

   always_comb begin
      for (int y = 0; y < MS; y++) begin
         for (int x = 0; x < MS; x++) begin
            use_mask[y*MS+x] = cols[x] & rows[y];
         end
      end
   end

   assign tile_idx  = {ty_ff, tx_ff};
   assign tile_ok   = cols[tx_ff] & rows[ty_ff];
   assign dirty_cur = dirty_ff[tile_idx];
   assign px = POS_W'(tx_ff) * POS_W'(TILE_SIZE) + POS_W'(ox_ff);
   assign py = POS_W'(ty_ff) * POS_W'(TILE_SIZE) + POS_W'(oy_ff);
   assign idx_full = IW'(py) * IW'(MAX_WIDTH) + IW'(px);
   assign bmask = byte_mask(pixel_bytes_ff);

   always_comb begin
      oor = !tile_ok;
      if (op_ff == fbtdm_pkg::OP_COMPARE) begin
         if ((32'(ox_ff) >= TILE_SIZE) || (32'(oy_ff) >= TILE_SIZE) ||
             (px >= POS_W'(eff_w)) || (py >= POS_W'(eff_h))) begin
            oor = 1'b1;
         end
      end
   end

   assign force_eff = force_ff | always_force_ff;
   assign diff      = ((ram_rdata ^ pix_ff) & bmask) != '0;
   assign changed   = (op_ff == fbtdm_pkg::OP_COMPARE) && !oor && !force_eff && diff;
   assign mark      = (op_ff == fbtdm_pkg::OP_COMPARE) && !oor && (force_eff || diff);

   // shadow port
   assign ram_re    = cmd.rd_en;
   assign ram_raddr = idx_full[AW-1:0];
   assign ram_we    = cmd.clear_step | (cmd.commit & changed);
   assign ram_waddr = cmd.clear_step ? clr_addr_ff : idx_full[AW-1:0];
   assign ram_wdata = cmd.clear_step ? '0 : ((ram_rdata & ~bmask) | (pix_ff & bmask));

   always_comb begin
      dirty_in     = dirty_ff;
      count_in     = count_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.clear_init) begin
         dirty_in    = use_mask;
         count_in    = use_count;
         clr_addr_in = '0;
      end else if (cmd.clear_step) begin
         clr_addr_in = clr_addr_ff + AW'(1);
      end
      if (cmd.commit) begin
         if (mark && !dirty_cur) begin
            dirty_in[tile_idx] = 1'b1;
            count_in           = count_ff + 7'd1;
         end
         if ((op_ff == fbtdm_pkg::OP_CLEAN) && tile_ok && dirty_cur) begin
            dirty_in[tile_idx] = 1'b0;
            if (count_ff != '0) begin
               count_in = count_ff - 7'd1;
            end
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, oor, count_in, changed, tile_ok & dirty_in[tile_idx]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= fbtdm_pkg::RST_FRAME_WIDTH;
         frame_height_ff <= fbtdm_pkg::RST_FRAME_HEIGHT;
         pixel_bytes_ff  <= fbtdm_pkg::RST_PIXEL_BYTES;
         always_force_ff <= fbtdm_pkg::RST_ALWAYS_FORCE;
      end else if (csr_valid) begin
         unique case (fbtdm_pkg::csr_index_type'(csr_addr))
            fbtdm_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            fbtdm_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            fbtdm_pkg::CSR_PIXEL_BYTES:  pixel_bytes_ff  <= csr_wdata[2:0];
            fbtdm_pkg::CSR_ALWAYS_FORCE: always_force_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff    <= fbtdm_pkg::op_type'(req_tuser);
         tx_ff    <= req_tdata[2:0];
         ty_ff    <= req_tdata[5:3];
         ox_ff    <= req_tdata[9:6];
         oy_ff    <= req_tdata[13:10];
         pix_ff   <= req_tdata[45:14];
         force_ff <= req_tdata[46];
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int y = 0; y < MS; y++) begin
            for (int x = 0; x < MS; x++) begin
               dirty_ff[y*MS+x] <= RST_COLS[x] & RST_ROWS[y];
            end
         end
         count_ff     <= 7'(fbtdm_pkg::count8(RST_COLS)) * 7'(fbtdm_pkg::count8(RST_ROWS));
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dirty_ff     <= dirty_in;
         count_ff     <= count_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.in_reset   = fbtdm_pkg::op_type'(req_tuser) == fbtdm_pkg::OP_RESET;
   assign sts.clear_last = clr_addr_ff == AW'(DEPTH - 1);
   assign sts.rsp_free   = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
